// ===== rtl/dasc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dasc_pkg;

   // item action codes
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_TARGET = 2'd1;
   localparam logic [1:0] ACT_MOVE   = 2'd2;
   localparam logic [1:0] ACT_STOP   = 2'd3;

   // configuration register indexes
   localparam logic CSR_NEAR_BAND = 1'b0;
   localparam logic CSR_FAR_BAND  = 1'b1;

   localparam int CSR_DATA_WIDTH = 12;
   localparam int NEAR_WIDTH     = 8;
   localparam int FAR_WIDTH      = 12;

   localparam logic [NEAR_WIDTH-1:0] NEAR_BAND_RESET = 8'd1;
   localparam logic [FAR_WIDTH-1:0]  FAR_BAND_RESET  = 12'd15;

   // motor drive / motion codes
   localparam logic [3:0] MOTION_STOP     = 4'h0;
   localparam logic [3:0] MOTION_CCW      = 4'h4;
   localparam logic [3:0] MOTION_CCW_FAST = 4'h6;
   localparam logic [3:0] MOTION_CW       = 4'h8;
   localparam logic [3:0] MOTION_CW_FAST  = 4'hA;
   localparam logic [1:0] FAST_ON         = 2'd2;
   localparam logic [1:0] FAST_OFF        = 2'd0;

   // manual speed codes
   localparam logic signed [2:0] SPEED_CW       = 3'sd1;
   localparam logic signed [2:0] SPEED_CW_FAST  = 3'sd2;
   localparam logic signed [2:0] SPEED_CCW      = -3'sd1;
   localparam logic signed [2:0] SPEED_CCW_FAST = -3'sd2;

   // encoder step results
   localparam logic [1:0] STEP_UP   = 2'd1;
   localparam logic [1:0] STEP_DOWN = 2'd3;

   localparam logic [7:0] BUTTONS_RELEASED = 8'hFF;
   localparam int BTN_SLOW = 4;
   localparam int BTN_CCW  = 6;
   localparam int BTN_CW   = 7;

   // narrow controller state
   typedef struct packed {
      logic [3:0] drive;
      logic [3:0] motion;
      logic       seek;
      logic [1:0] fast;
      logic [7:0] last_buttons;
      logic [1:0] prev_phase;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{
      drive:        MOTION_STOP,
      motion:       MOTION_STOP,
      seek:         1'b0,
      fast:         FAST_OFF,
      last_buttons: BUTTONS_RELEASED,
      prev_phase:   2'd0
   };

   // position of a phase code along the up sequence 0-1-3-2
   function automatic logic [1:0] phase_pos(input logic [1:0] code);
      phase_pos = {code[1], code[1] ^ code[0]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dasc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dasc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [7:0]        button_port;
   logic [1:0]        encoder_phase;
   logic              index_low;
   logic              disable_high;
   logic signed [15:0] target;
   logic signed [2:0] move_speed;

   modport source (
      output valid, action, button_port, encoder_phase, index_low, disable_high,
             target, move_speed,
      input  ready
   );
   modport sink (
      input  valid, action, button_port, encoder_phase, index_low, disable_high,
             target, move_speed,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/dasc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dasc_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         drive_code;
   logic [3:0]         motion_code;
   logic signed [15:0] azimuth_count;
   logic               seek_active;

   modport source (
      output valid, drive_code, motion_code, azimuth_count, seek_active,
      input  ready
   );
   modport sink (
      input  valid, drive_code, motion_code, azimuth_count, seek_active,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/dasc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// next-state logic for one item
module dasc_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  var dasc_pkg::ctrl_type        ctrl_cur,
   input  var logic [COUNT_WIDTH-1:0]    count_cur,
   input  var logic [COUNT_WIDTH-1:0]    target_cur,
   input  var logic [1:0]                action,
   input  var logic [7:0]                button_port,
   input  var logic [1:0]                encoder_phase,
   input  var logic                      index_low,
   input  var logic                      disable_high,
   input  var logic signed [15:0]        target,
   input  var logic signed [2:0]         move_speed,
   input  var logic [dasc_pkg::NEAR_WIDTH-1:0] near_band,
   input  var logic [dasc_pkg::FAR_WIDTH-1:0]  far_band,
   output dasc_pkg::ctrl_type            ctrl_nxt,
   output logic [COUNT_WIDTH-1:0]        count_nxt,
   output logic [COUNT_WIDTH-1:0]        target_nxt
);

   // error compare width: holds the count error and the 12-bit band, plus sign
   localparam int EW = ((COUNT_WIDTH > dasc_pkg::FAR_WIDTH + 1) ?
                        COUNT_WIDTH : dasc_pkg::FAR_WIDTH + 1) + 1;

   logic signed [COUNT_WIDTH-1:0] err_s;
   logic signed [EW-1:0]          err_x;
   logic signed [EW-1:0]          far_x;
   logic signed [EW-1:0]          near_x;
   logic [1:0]                    step;
   logic [7:0]                    old_btn;

   assign err_s  = $signed(target_cur - count_cur);  // short way round
   assign err_x  = EW'(err_s);
   assign far_x  = $signed(EW'(far_band));
   assign near_x = $signed(EW'(near_band));
   assign step   = dasc_pkg::phase_pos(encoder_phase) -
                   dasc_pkg::phase_pos(ctrl_cur.prev_phase);
   assign old_btn = ctrl_cur.last_buttons;

   always_comb begin
      ctrl_nxt   = ctrl_cur;
      count_nxt  = count_cur;
      target_nxt = target_cur;
      case (action)
         dasc_pkg::ACT_TICK: begin
            ctrl_nxt.drive = disable_high ? dasc_pkg::MOTION_STOP : ctrl_cur.motion;
            // seek: far band checked first
            if (ctrl_cur.seek) begin
               if (err_x > far_x) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_CW_FAST;
               end else if (err_x > near_x) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_CW;
               end else if (err_x < -far_x) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_CCW_FAST;
               end else if (err_x < -near_x) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_CCW;
               end else begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_STOP;
                  ctrl_nxt.seek   = 1'b0;
               end
            end
            // button edges, cw after ccw so cw wins
            if (button_port != old_btn) begin
               ctrl_nxt.fast = button_port[dasc_pkg::BTN_SLOW] ?
                               dasc_pkg::FAST_ON : dasc_pkg::FAST_OFF;
               if (old_btn[dasc_pkg::BTN_CCW] && !button_port[dasc_pkg::BTN_CCW]) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_CCW | {2'b00, ctrl_nxt.fast};
                  ctrl_nxt.seek   = 1'b0;
               end
               if (!old_btn[dasc_pkg::BTN_CCW] && button_port[dasc_pkg::BTN_CCW]) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_STOP;
                  ctrl_nxt.seek   = 1'b0;
               end
               if (old_btn[dasc_pkg::BTN_CW] && !button_port[dasc_pkg::BTN_CW]) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_CW | {2'b00, ctrl_nxt.fast};
                  ctrl_nxt.seek   = 1'b0;
               end
               if (!old_btn[dasc_pkg::BTN_CW] && button_port[dasc_pkg::BTN_CW]) begin
                  ctrl_nxt.motion = dasc_pkg::MOTION_STOP;
                  ctrl_nxt.seek   = 1'b0;
               end
               ctrl_nxt.last_buttons = button_port;
            end
            // encoder: jumps of two and no change leave the count
            if (step == dasc_pkg::STEP_UP) begin
               count_nxt = count_cur + COUNT_WIDTH'(1);
            end else if (step == dasc_pkg::STEP_DOWN) begin
               count_nxt = count_cur - COUNT_WIDTH'(1);
            end
            ctrl_nxt.prev_phase = encoder_phase;
            if (!index_low) begin
               count_nxt = '0;
            end
         end
         dasc_pkg::ACT_TARGET: begin
            target_nxt    = COUNT_WIDTH'(target);
            ctrl_nxt.seek = 1'b1;
         end
         dasc_pkg::ACT_MOVE: begin
            case (move_speed)
               dasc_pkg::SPEED_CW:       ctrl_nxt.motion = dasc_pkg::MOTION_CW;
               dasc_pkg::SPEED_CW_FAST:  ctrl_nxt.motion = dasc_pkg::MOTION_CW_FAST;
               dasc_pkg::SPEED_CCW:      ctrl_nxt.motion = dasc_pkg::MOTION_CCW;
               dasc_pkg::SPEED_CCW_FAST: ctrl_nxt.motion = dasc_pkg::MOTION_CCW_FAST;
               default:                  ctrl_nxt.motion = dasc_pkg::MOTION_STOP;
            endcase
         end
         default: begin
            ctrl_nxt.motion = dasc_pkg::MOTION_STOP;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/dome_azimuth_seek_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Dome azimuth seek controller. Each request transfer carries one action: a
// tick (latch drive code, step the two-speed seek, handle button edges, count
// the quadrature encoder, clear on index), a new target that starts the seek,
// a forced manual speed, or stop. Every request gives exactly one response
// with the latched drive code, the motion code, the low 16 bits of the
// azimuth count and the seek flag. Throughput is one request per clock while rsp_chan
// does not stall: the whole update is a single pass of logic from the state registers
// into the next state and the response register, and the response shows up the cycle
// after its request. The response register lets a new request be taken while an earlier
// response waits, as long as rsp_chan.ready is high that cycle. The user must write
// near_band / far_band through the csr_ port only while idle; the block does not enforce it.
module dome_azimuth_seek_controller #(
   parameter int COUNT_WIDTH = 16   // azimuth counter width, 8..32
) (
   input  var logic                                clock,
   input  var logic                                reset,
   dasc_req_if.sink                                req_chan,
   dasc_rsp_if.source                              rsp_chan,
   input  var logic                                csr_we,
   input  var logic                                csr_index,
   input  var logic [dasc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   // architectural state
   dasc_pkg::ctrl_type               ctrl_ff, ctrl_in;
   logic [COUNT_WIDTH-1:0]           count_ff, count_in;
   logic [COUNT_WIDTH-1:0]           target_ff, target_in;
   logic [dasc_pkg::NEAR_WIDTH-1:0]  near_band_ff;
   logic [dasc_pkg::FAR_WIDTH-1:0]   far_band_ff;

   // response register
   logic                             rsp_valid_ff;
   logic [3:0]                       rsp_drive_ff;
   logic [3:0]                       rsp_motion_ff;
   logic signed [15:0]               rsp_count_ff;
   logic                             rsp_seek_ff;

   logic                             req_xfer;

   // take a new request whenever the response slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   dasc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .ctrl_cur      (ctrl_ff),
      .count_cur     (count_ff),
      .target_cur    (target_ff),
      .action        (req_chan.action),
      .button_port   (req_chan.button_port),
      .encoder_phase (req_chan.encoder_phase),
      .index_low     (req_chan.index_low),
      .disable_high  (req_chan.disable_high),
      .target        (req_chan.target),
      .move_speed    (req_chan.move_speed),
      .near_band     (near_band_ff),
      .far_band      (far_band_ff),
      .ctrl_nxt      (ctrl_in),
      .count_nxt     (count_in),
      .target_nxt    (target_in)
   );

   // state commits only on a request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= dasc_pkg::CTRL_RESET;
         count_ff  <= '0;
         target_ff <= '0;
      end else if (req_xfer) begin
         ctrl_ff   <= ctrl_in;
         count_ff  <= count_in;
         target_ff <= target_in;
      end
   end

   // band registers
   always_ff @(posedge clock) begin
      if (reset) begin
         near_band_ff <= dasc_pkg::NEAR_BAND_RESET;
         far_band_ff  <= dasc_pkg::FAR_BAND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dasc_pkg::CSR_NEAR_BAND: near_band_ff <= csr_wdata[dasc_pkg::NEAR_WIDTH-1:0];
            dasc_pkg::CSR_FAR_BAND:  far_band_ff  <= csr_wdata[dasc_pkg::FAR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // response valid: set by a request transfer, cleared by a response transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_drive_ff  <= ctrl_in.drive;
         rsp_motion_ff <= ctrl_in.motion;
         rsp_count_ff  <= $signed(16'(count_in));  // low 16 bits, zero-filled if narrower
         rsp_seek_ff   <= ctrl_in.seek;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.drive_code    = rsp_drive_ff;
   assign rsp_chan.motion_code   = rsp_motion_ff;
   assign rsp_chan.azimuth_count = rsp_count_ff;
   assign rsp_chan.seek_active   = rsp_seek_ff;

endmodule

`default_nettype wire
